// ----- rtl/core/dlz_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlz_pkg
// Shared types, constants and zone table lookups for the zoned-disk
// address translator.
// ----------------------------------------------------------------------------
package dlz_pkg;

    localparam int unsigned ZONE_SLOTS        = 16;
    localparam int unsigned ZONE_COUNT        = 9;
    localparam int unsigned TYPE_COUNT        = 7;
    localparam int unsigned SECTORS_PER_BLOCK = 85;

    localparam int unsigned LBA_W    = 13;
    localparam int unsigned SECTOR_W = 7;
    localparam int unsigned TRACK_W  = 12;
    localparam int unsigned SIDX_W   = 8;
    localparam int unsigned SIZE_W   = 8;
    localparam int unsigned DTYPE_W  = 3;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned ZONE_W   = 4;
    localparam int unsigned ZTRK_W   = 8;

    // Highest legal disk type; larger codes saturate to it.
    localparam logic [DTYPE_W-1:0] DTYPE_MAX = DTYPE_W'(TYPE_COUNT - 1);

    typedef logic [ZONE_W-1:0] zone_row_t [ZONE_SLOTS];

    localparam zone_row_t SLOT_ZONE [TYPE_COUNT] = '{
        '{4'd0, 4'd1, 4'd2, 4'd2, 4'd1, 4'd3, 4'd4, 4'd5,
          4'd6, 4'd7, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd2, 4'd1, 4'd4,
          4'd5, 4'd6, 4'd7, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd2,
          4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd7, 4'd6, 4'd5},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd5, 4'd4,
          4'd3, 4'd2, 4'd1, 4'd6, 4'd7, 4'd8, 4'd7, 4'd6},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6,
          4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd7, 4'd8, 4'd7},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd8},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1}
    };

    localparam logic [SIZE_W-1:0] ZONE_BYTES [ZONE_COUNT] = '{
        8'd232, 8'd216, 8'd208, 8'd192, 8'd176, 8'd160, 8'd144, 8'd128, 8'd112
    };

    localparam logic [ZTRK_W-1:0] ZONE_TRK_H0 [ZONE_COUNT] = '{
        8'd150, 8'd150, 8'd141, 8'd141, 8'd141, 8'd141, 8'd141, 8'd106, 8'd0
    };

    localparam logic [ZTRK_W-1:0] ZONE_TRK_H1 [ZONE_COUNT] = '{
        8'd0, 8'd150, 8'd150, 8'd141, 8'd141, 8'd141, 8'd141, 8'd141, 8'd106
    };

    // Word handed from one cell to the next.
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [SIDX_W-1:0]  sector_index;
        logic [TRACK_W-1:0] total;
        logic               found;
        logic [SIZE_W-1:0]  sector_size;
    } dlz_word_t;

    // Zone of a slot for a (saturated) disk type.
    function automatic logic [ZONE_W-1:0] slot_zone(input logic [DTYPE_W-1:0] dt,
                                                    input logic [SLOT_W-1:0] slot);
        logic [DTYPE_W-1:0] d;
        d = (dt > DTYPE_MAX) ? DTYPE_MAX : dt;
        return SLOT_ZONE[d][slot];
    endfunction

    // Track count contributed by a slot, following the ROM/RAM head rules.
    function automatic logic [ZTRK_W-1:0] slot_tracks(input logic [DTYPE_W-1:0] dt,
                                                      input logic [SLOT_W-1:0] slot);
        logic [ZONE_W-1:0] z;
        logic [4:0]        d5;
        logic [4:0]        s5;
        logic              head1;
        z  = slot_zone(dt, slot);
        d5 = {2'b00, dt};
        s5 = {1'b0, slot};
        if ({1'b0, z} <= d5 + 5'd2) begin
            head1 = !(s5 <= d5 + 5'd2);
        end else begin
            head1 = !((s5 > 5'd5 + {d5[3:0], 1'b0}) && (s5 < 5'd10 + d5));
        end
        return head1 ? ZONE_TRK_H1[z] : ZONE_TRK_H0[z];
    endfunction

    function automatic logic [SIZE_W-1:0] slot_bytes(input logic [DTYPE_W-1:0] dt,
                                                     input logic [SLOT_W-1:0] slot);
        return ZONE_BYTES[slot_zone(dt, slot)];
    endfunction

endpackage

// ----- rtl/core/disk_lba_zone_translate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_lba_zone_translate
// Zoned-disk logical block address to track, sector start and sector size.
// ----------------------------------------------------------------------------
// Each input word carries a logical block address and a sector offset; each
// output word gives the physical track (the address shifted right by one),
// the sector start index (the offset plus one block of 85 sectors when
// address bits 1 and 0 differ), the byte size of a sector in the track's
// zone, and a valid flag in m_tuser that is low, with a size of zero, when
// the track lies past every zone. The zone lookup runs through a row of 16
// cells, one per zone slot of the selected disk type, each adding its slot's
// track count to a running total and claiming the size on the first total
// above the track. The block takes one word per cycle while the output is not
// stalled, and each word passes through the registers of all 16 cells in turn.
// Each cell holds a word and moves it on as soon as its neighbor has room, so
// gaps in the row close up under backpressure.
// The disk type is written through the cfg port (codes above 6 act as 6) and
// must only change while the block holds no word.
// ----------------------------------------------------------------------------
module disk_lba_zone_translate (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: cfg_data = disk_type[2:0].
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // s_tdata: lba[12:0], sector[19:13], zero fill [23:20].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: track[11:0], sector_index[19:12], sector_size[27:20],
    // zero fill [31:28].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: valid_res[0].
    output logic [0:0]  m_tuser
);
    import dlz_pkg::*;

    logic [DTYPE_W-1:0] dtype_reg;
    logic [DTYPE_W-1:0] dtype_next;

    logic [ZTRK_W-1:0]  slot_trk  [ZONE_SLOTS];
    logic [SIZE_W-1:0]  slot_size [ZONE_SLOTS];

    logic               chain_valid [ZONE_SLOTS+1];
    logic               chain_ready [ZONE_SLOTS+1];
    dlz_word_t          chain_word  [ZONE_SLOTS+1];

    logic [LBA_W-1:0]    in_lba;
    logic [SECTOR_W-1:0] in_sector;
    logic                odd_half;
    dlz_word_t           last_word;

    // Configuration: always ready, stored already saturated to a legal type.
    assign cfg_ready  = 1'b1;
    assign dtype_next = (cfg_data > DTYPE_MAX) ? DTYPE_MAX : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dtype_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            dtype_reg <= dtype_next;
        end
    end

    // Per-slot track counts and sizes of the selected disk type.
    always_comb begin
        for (int i = 0; i < ZONE_SLOTS; i++) begin
            slot_trk[i]  = slot_tracks(dtype_reg, SLOT_W'(i));
            slot_size[i] = slot_bytes(dtype_reg, SLOT_W'(i));
        end
    end

    // Entry of the cell row: the track and sector index are settled here,
    // the zone search starts from an empty running total.
    assign in_lba    = s_tdata[LBA_W-1:0];
    assign in_sector = s_tdata[LBA_W +: SECTOR_W];
    assign odd_half  = in_lba[1] ^ in_lba[0];

    always_comb begin
        chain_word[0].track        = in_lba[LBA_W-1:1];
        chain_word[0].sector_index = SIDX_W'(in_sector)
                                   + (odd_half ? SIDX_W'(SECTORS_PER_BLOCK) : '0);
        chain_word[0].total        = '0;
        chain_word[0].found        = 1'b0;
        chain_word[0].sector_size  = '0;
    end

    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    for (genvar g = 0; g < ZONE_SLOTS; g++) begin : g_cell
        dlz_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_word   (chain_word[g]),
            .slot_trk  (slot_trk[g]),
            .slot_size (slot_size[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_word  (chain_word[g+1])
        );
    end

    // The last cell's register is the output register.
    assign last_word               = chain_word[ZONE_SLOTS];
    assign chain_ready[ZONE_SLOTS] = m_tready;
    assign m_tvalid                = chain_valid[ZONE_SLOTS];
    assign m_tdata                 = {4'b0000, last_word.sector_size,
                                      last_word.sector_index, last_word.track};
    assign m_tuser                 = last_word.found;

    // An out-of-range track reports a zero size, a hit never does.
    a_miss_zero_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (last_word.sector_size == '0))
        else $error("miss reported with nonzero sector size");

    a_hit_nonzero_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (last_word.sector_size != '0))
        else $error("hit reported with zero sector size");

    // With nothing waiting at the output the whole row has room.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // The stored disk type is always a legal, saturated code.
    a_dtype_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        dtype_reg <= DTYPE_MAX)
        else $error("disk type register out of range");

endmodule

// ----- rtl/core/dlz_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlz_cell
// One zone slot: adds the slot's track count to the running total and
// claims the zone's sector size when the track first falls below it.
// ----------------------------------------------------------------------------
module dlz_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dlz_pkg::dlz_word_t                  in_word,
    input  logic [dlz_pkg::ZTRK_W-1:0]          slot_trk,
    input  logic [dlz_pkg::SIZE_W-1:0]          slot_size,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dlz_pkg::dlz_word_t                  out_word
);
    import dlz_pkg::*;

    logic               valid_reg;
    dlz_word_t          word_reg;
    dlz_word_t          word_next;
    logic [TRACK_W-1:0] sum;
    logic               hit;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sum       = in_word.total + TRACK_W'(slot_trk);
        hit       = !in_word.found && (in_word.track < sum);
        word_next = in_word;
        word_next.total = sum;
        if (hit) begin
            word_next.found       = 1'b1;
            word_next.sector_size = slot_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
